// ===== rtl/krb_pkg.sv =====
// Shared constants, types and register codes for the keyboard rollover report builder.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package krb_pkg;

   localparam int KEY_COUNT    = 128;
   localparam int LAYER_COUNT  = 4;
   localparam int REPORT_SLOTS = 6;

   // Fixed by the field widths of the transactions.
   localparam int KEY_W    = 7;
   localparam int LAYER_W  = 2;
   localparam int CODE_W   = 8;
   localparam int ENTRY_W  = CODE_W + 1;
   localparam int OUT_SLOTS = 6;
   localparam int SLOT_CW  = $clog2(OUT_SLOTS);
   localparam int REQ_W    = 24;
   localparam int RSP_W    = 64;
   localparam int CSR_IDX_W = 2;

   localparam int KEY_AW    = $clog2(KEY_COUNT);
   localparam int MAP_DEPTH = LAYER_COUNT * KEY_COUNT;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);

   localparam logic [LAYER_W-1:0] FN_LAYER = 2'd3;
   localparam int SHIFT_BASE = 32;
   localparam int ROWS       = 6;

   localparam logic [KEY_W-1:0]   CYCLE_KEY_RST = 7'd31;
   localparam logic [KEY_W-1:0]   FN_KEY_RST    = 7'd37;
   localparam logic [2:0]         CYCLED_RST    = 3'd3;
   localparam logic [CODE_W-1:0]  INJ_MOD_RST   = 8'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CYCLE_KEY = 2'd0,
      CSR_FN_KEY    = 2'd1,
      CSR_CYCLED    = 2'd2,
      CSR_INJ_MOD   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SLOT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]  cycle_key;
      logic [KEY_W-1:0]  fn_key;
      logic [2:0]        cycled_layers;
      logic [CODE_W-1:0] inj_mod;
   } cfg_type;

   typedef struct packed {
      logic             push;
      logic             remove;
      logic [KEY_W-1:0] key;
   } queue_cmd_type;

   typedef struct packed {
      logic [OUT_SLOTS-1:0]            vld;
      logic [OUT_SLOTS-1:0][KEY_W-1:0] key;
   } queue_view_type;

endpackage

`default_nettype wire

// ===== rtl/keyboard_rollover_report_builder_unit.sv =====
// Top level: stream ports, the configuration registers, the sequencer and the queue.
// An edge sample runs lookup, slot and finish, loads its report once the output register
// is free and takes the next request in the cycle after; a non-edge sample returns to
// idle from lookup, a keymap write stays in idle. The keymap has a single read port: one
// read for the key's own entry, six for the report slots. Reset is synchronous and clears
// held keys, queue, modifiers, layer and registers; the keymap needs writing first.
`default_nettype none

module keyboard_rollover_report_builder_unit (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // key_index[6:0], key_level[7], map_layer[9:8], map_code[17:10],
   // map_is_modifier[18], zero fill above
   input  wire [krb_pkg::REQ_W-1:0]        req_tdata,
   // mode[0]
   input  wire                             req_tuser,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // slot_code_0[7:0] .. slot_code_5[47:40], modifier_byte[55:48],
   // active_layer[57:56], zero fill above
   output logic [krb_pkg::RSP_W-1:0]       rsp_tdata,
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire [krb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [7:0]                       csr_data
);
   import krb_pkg::*;

   cfg_type        cfg_ff;
   queue_cmd_type  qcmd;
   queue_view_type qview;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cycle_key     <= CYCLE_KEY_RST;
         cfg_ff.fn_key        <= FN_KEY_RST;
         cfg_ff.cycled_layers <= CYCLED_RST;
         cfg_ff.inj_mod       <= INJ_MOD_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_CYCLE_KEY: cfg_ff.cycle_key     <= csr_data[KEY_W-1:0];
            CSR_FN_KEY:    cfg_ff.fn_key        <= csr_data[KEY_W-1:0];
            CSR_CYCLED:    cfg_ff.cycled_layers <= csr_data[2:0];
            CSR_INJ_MOD:   cfg_ff.inj_mod       <= csr_data;
            default:       cfg_ff <= cfg_ff;
         endcase
      end
   end

   krb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_mode      (req_tuser),
      .req_key       (req_tdata[6:0]),
      .req_down      (req_tdata[7]),
      .req_map_layer (req_tdata[9:8]),
      .req_map_code  (req_tdata[17:10]),
      .req_map_mod   (req_tdata[18]),
      .cfg           (cfg_ff),
      .qview         (qview),
      .qcmd          (qcmd),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

   krb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (qcmd),
      .view  (qview)
   );

endmodule

`default_nettype wire

// ===== rtl/krb_queue.sv =====
// Most-recent-first rollover queue of held key indexes, kept in flip-flops.
// Depends on krb_pkg for the slot count and the command and view structs.
`default_nettype none

module krb_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  krb_pkg::queue_cmd_type  cmd,
   output krb_pkg::queue_view_type view
);
   import krb_pkg::*;

   logic [KEY_W-1:0]        key_ff [REPORT_SLOTS];
   logic [KEY_W-1:0]        key_in [REPORT_SLOTS];
   logic [REPORT_SLOTS-1:0] vld_ff;
   logic [REPORT_SLOTS-1:0] vld_in;

   always_comb begin
      logic upto;
      upto = 1'b0;
      key_in = key_ff;
      vld_in = vld_ff;
      if (cmd.push) begin
         for (int i = REPORT_SLOTS - 1; i > 0; i--) begin
            key_in[i] = key_ff[i-1];
            vld_in[i] = vld_ff[i-1];
         end
         key_in[0] = cmd.key;
         vld_in[0] = 1'b1;
      end else if (cmd.remove) begin
         // Every slot at or after the first match takes its successor; the last one is cleared.
         for (int i = 0; i < REPORT_SLOTS; i++) begin
            upto = upto | (vld_ff[i] && (key_ff[i] == cmd.key));
            if (upto) begin
               if (i == REPORT_SLOTS - 1) begin
                  vld_in[i] = 1'b0;
               end else begin
                  key_in[i] = key_ff[i+1];
                  vld_in[i] = vld_ff[i+1];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   for (genvar g = 0; g < OUT_SLOTS; g++) begin : g_view
      if (g < REPORT_SLOTS) begin : g_live
         assign view.vld[g] = vld_ff[g];
         assign view.key[g] = key_ff[g];
      end else begin : g_dead
         assign view.vld[g] = 1'b0;
         assign view.key[g] = '0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/krb_ctrl.sv =====
// Sequencer with the keymap memory and the held-key memory: edge detection,
// modifier and layer tracking, report lookups and the report output register.
// Depends on krb_pkg and drives the rollover queue in krb_queue.
`default_nettype none

module krb_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire                          req_mode,
   input  wire [krb_pkg::KEY_W-1:0]     req_key,
   input  wire                          req_down,
   input  wire [krb_pkg::LAYER_W-1:0]   req_map_layer,
   input  wire [krb_pkg::CODE_W-1:0]    req_map_code,
   input  wire                          req_map_mod,
   input  krb_pkg::cfg_type             cfg,
   input  krb_pkg::queue_view_type      qview,
   output krb_pkg::queue_cmd_type       qcmd,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [krb_pkg::RSP_W-1:0]    rsp_tdata
);
   import krb_pkg::*;

   localparam int SHIFT_COLS = (2**KEY_W - SHIFT_BASE + ROWS - 1) / ROWS;

   function automatic logic [MAP_AW-1:0] map_addr(input logic [LAYER_W-1:0] layer,
                                                  input logic [KEY_W-1:0] key);
      return MAP_AW'(32'(layer) * KEY_COUNT + 32'(key));
   endfunction

   function automatic logic key_ok(input logic [KEY_W-1:0] key);
      return 32'(key) < KEY_COUNT;
   endfunction

   // Row two from column five on: SHIFT_BASE plus a multiple of ROWS.
   function automatic logic is_shift_key(input logic [KEY_W-1:0] key);
      logic hit;
      hit = 1'b0;
      for (int c = 0; c < SHIFT_COLS; c++) begin
         hit = hit | (32'(key) == SHIFT_BASE + ROWS * c);
      end
      return hit;
   endfunction

   state_type state_ff, state_in;

   logic [KEY_W-1:0]   key_ff;
   logic               down_ff;
   logic               press_ff;
   logic [LAYER_W-1:0] layer_ff, layer_in;
   logic [CODE_W-1:0]  mods_ff, mods_in;
   logic [SLOT_CW-1:0] slot_cnt_ff;
   logic [SLOT_CW-1:0] pend_idx_ff;
   logic               pend_ff;
   logic [CODE_W-1:0]  code_ff [OUT_SLOTS];
   logic               rsp_valid_ff;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [ENTRY_W-1:0] map_mem [MAP_DEPTH];
   logic [ENTRY_W-1:0] map_q_ff;
   logic [MAP_AW-1:0]  map_rd_addr;
   logic               map_we;

   logic               held_mem [KEY_COUNT];
   logic               held_q_ff;
   logic [KEY_COUNT-1:0] held_vld_ff;
   logic               held_vq_ff;
   logic               held_we;

   logic               accept;
   logic               lay_ok;
   logic               entry_mod;
   logic [CODE_W-1:0]  entry_code;
   logic               is_edge;
   logic               fn_case;
   logic               rsp_load;
   logic               shift_hit;
   logic [LAYER_W:0]   nxt_wide;
   logic [LAYER_W-1:0] nxt_layer;

   assign accept     = req_tvalid && req_tready;
   assign lay_ok     = 32'(layer_ff) < LAYER_COUNT;
   assign entry_mod  = lay_ok && map_q_ff[CODE_W];
   assign entry_code = lay_ok ? map_q_ff[CODE_W-1:0] : '0;
   assign is_edge    = down_ff != (held_vq_ff && held_q_ff);
   assign fn_case    = (key_ff == cfg.fn_key) &&
                       (down_ff ? (layer_ff == '0) : (layer_ff == FN_LAYER));
   assign map_we     = accept && req_mode && key_ok(req_key) &&
                       (32'(req_map_layer) < LAYER_COUNT);
   assign held_we    = (state_ff == ST_LOOKUP) && is_edge;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !req_mode && key_ok(req_key)) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = is_edge ? ST_SLOT : ST_IDLE;
         end
         ST_SLOT: begin
            if (slot_cnt_ff == SLOT_CW'(OUT_SLOTS - 1)) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      map_rd_addr = map_addr(layer_ff, req_key);
      rsp_load    = 1'b0;
      qcmd        = '0;
      qcmd.key    = key_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_LOOKUP: begin
            if (is_edge && !entry_mod && !fn_case) begin
               qcmd.push   = down_ff;
               qcmd.remove = !down_ff;
            end
         end
         ST_SLOT: begin
            map_rd_addr = map_addr(layer_ff, qview.key[slot_cnt_ff]);
         end
         ST_FINISH: begin
            rsp_load = !pend_ff && (!rsp_valid_ff || rsp_tready);
         end
         default: req_tready = 1'b0;
      endcase
   end

   always_comb begin
      nxt_wide  = {1'b0, layer_ff} + 1'b1;
      nxt_layer = nxt_wide[LAYER_W-1:0];
      if ((nxt_wide >= cfg.cycled_layers) || (nxt_wide > {1'b0, FN_LAYER})) nxt_layer = '0;
   end

   always_comb begin
      mods_in  = mods_ff;
      layer_in = layer_ff;
      if (held_we) begin
         if (entry_mod) begin
            mods_in = down_ff ? (mods_ff | entry_code) : (mods_ff & ~entry_code);
         end else if (fn_case) begin
            layer_in = down_ff ? FN_LAYER : '0;
         end
      end
      // The cycle key steps the layer only after its report is built.
      if (rsp_load && press_ff && (key_ff == cfg.cycle_key)) layer_in = nxt_layer;
   end

   always_comb begin
      shift_hit = 1'b0;
      for (int i = 0; i < OUT_SLOTS; i++) begin
         shift_hit = shift_hit | (qview.vld[i] && is_shift_key(qview.key[i]));
      end
      rsp_data_in = '0;
      for (int i = 0; i < OUT_SLOTS; i++) begin
         rsp_data_in[i*CODE_W +: CODE_W] = code_ff[i];
      end
      rsp_data_in[OUT_SLOTS*CODE_W +: CODE_W] =
         mods_ff | (((layer_ff == FN_LAYER) && shift_hit) ? cfg.inj_mod : '0);
      rsp_data_in[(OUT_SLOTS+1)*CODE_W +: LAYER_W] = layer_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         layer_ff     <= '0;
         mods_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         held_vld_ff  <= '0;
      end else begin
         state_ff <= state_in;
         layer_ff <= layer_in;
         mods_ff  <= mods_in;
         pend_ff  <= (state_ff == ST_SLOT);
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (held_we) held_vld_ff[KEY_AW'(key_ff)] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff  <= req_key;
         down_ff <= req_down;
      end
      if (held_we) press_ff <= down_ff;
      if (state_ff == ST_LOOKUP) begin
         slot_cnt_ff <= '0;
      end else if (state_ff == ST_SLOT) begin
         slot_cnt_ff <= slot_cnt_ff + 1'b1;
      end
      pend_idx_ff <= slot_cnt_ff;
      if (pend_ff) begin
         code_ff[pend_idx_ff] <= (qview.vld[pend_idx_ff] && lay_ok) ?
                                 map_q_ff[CODE_W-1:0] : '0;
      end
      if (rsp_load) rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_addr(req_map_layer, req_key)] <= {req_map_mod, req_map_code};
      map_q_ff <= map_mem[map_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (held_we) held_mem[KEY_AW'(key_ff)] <= down_ff;
      held_q_ff  <= held_mem[KEY_AW'(req_key)];
      held_vq_ff <= held_vld_ff[KEY_AW'(req_key)];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/krb_checker.sv =====
// Port-level checks for the report builder, attached to the top level by bind.
// Depends on krb_pkg for the port widths.
`default_nettype none

module krb_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_tvalid,
   input wire                          req_tready,
   input wire [krb_pkg::REQ_W-1:0]     req_tdata,
   input wire                          req_tuser,
   input wire                          rsp_tvalid,
   input wire                          rsp_tready,
   input wire [krb_pkg::RSP_W-1:0]     rsp_tdata
);
   import krb_pkg::*;

   // A stalled report holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("report changed while stalled");

   // A keymap write finishes in the cycle it is taken.
   a_map_write: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> req_tready)
      else $error("not ready after a keymap write");

   // A key sample in range always goes to its lookup.
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && (32'(req_tdata[6:0]) < KEY_COUNT)
      |=> !req_tready)
      else $error("ready during a key lookup");

   // A new report only appears while a sample is in work.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("report appeared while idle");

endmodule

bind keyboard_rollover_report_builder_unit krb_checker u_checker (.*);

`default_nettype wire
